// File: hdl/hsv_pkg.sv
// ----------------------------------------------------------------------------
// hsv_pkg
// Shared beat types, stage payloads, constants and the divide-by-255 helper
// for the hsv to rgb pipeline.
// ----------------------------------------------------------------------------
package hsv_pkg;

  localparam int unsigned ChanW   = 8;
  localparam int unsigned HueW    = 16;
  localparam int unsigned FracW   = 16;
  localparam int unsigned SectorW = 3;
  localparam int unsigned NumW    = 24;

  localparam logic [2:0]        Sectors = 3'd6;
  localparam logic [ChanW-1:0]  Full    = 8'd255;
  // 255 * 65536, the common denominator of the q and t levels
  localparam logic [NumW-1:0]   Den     = 24'd16711680;
  // floor(y / 255) == (y * 0x8081) >> 23 for every 16-bit y
  localparam logic [15:0]       Recip255 = 16'h8081;
  localparam int unsigned       RecipSh  = 23;

  typedef enum logic [SectorW-1:0] {
    SEC_RED     = 3'd0,
    SEC_YELLOW  = 3'd1,
    SEC_GREEN   = 3'd2,
    SEC_CYAN    = 3'd3,
    SEC_BLUE    = 3'd4,
    SEC_MAGENTA = 3'd5
  } sector_e;

  typedef struct packed {
    logic [HueW-1:0]  hue;
    logic [ChanW-1:0] saturation;
    logic [ChanW-1:0] brightness;
  } hsv_in_t;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } rgb_out_t;

  typedef struct packed {
    sector_e          sector;
    logic [FracW-1:0] frac;
    logic [ChanW-1:0] sat;
    logic [ChanW-1:0] val;
  } st1_t;

  typedef struct packed {
    sector_e          sector;
    logic [NumW-1:0]  sf;
    logic [15:0]      pv;
    logic [ChanW-1:0] sat;
    logic [ChanW-1:0] val;
  } st2_t;

  typedef struct packed {
    sector_e          sector;
    logic [15:0]      yq;
    logic [15:0]      yt;
    logic [15:0]      pv;
    logic [ChanW-1:0] val;
  } st3_t;

  typedef struct packed {
    sector_e          sector;
    logic [ChanW-1:0] val;
    logic [ChanW-1:0] lp;
    logic [ChanW-1:0] lq;
    logic [ChanW-1:0] lt;
  } st4_t;

  function automatic logic [ChanW-1:0] div255(input logic [15:0] y);
    logic [31:0] m;
    m = 32'(y) * 32'(Recip255);
    return m[RecipSh+ChanW-1:RecipSh];
  endfunction

endpackage

// File: hdl/hsv_front.sv
// ----------------------------------------------------------------------------
// hsv_front
// Stages one and two: sector and fraction split, then the s*f and p products.
// ----------------------------------------------------------------------------
module hsv_front import hsv_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [1:0] en_i,
  input  logic       valid_i,
  input  hsv_in_t    data_i,
  output logic [1:0] valid_o,
  output st2_t       data_o
);

  logic [1:0] valid_q;
  st1_t       s1_d, s1_q;
  st2_t       s2_d, s2_q;
  logic [18:0] x;

  always_comb begin
    x = 19'(data_i.hue) * 19'(Sectors);
    s1_d.sector = sector_e'(x[18:16]);
    s1_d.frac   = x[15:0];
    s1_d.sat    = data_i.saturation;
    s1_d.val    = data_i.brightness;
  end

  always_comb begin
    s2_d.sector = s1_q.sector;
    s2_d.sf     = NumW'(s1_q.sat) * NumW'(s1_q.frac);
    s2_d.pv     = 16'(s1_q.val) * 16'(Full - s1_q.sat);
    s2_d.sat    = s1_q.sat;
    s2_d.val    = s1_q.val;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en_i[0]) valid_q[0] <= valid_i;
      if (en_i[1]) valid_q[1] <= valid_q[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) s1_q <= s1_d;
    if (en_i[1]) s2_q <= s2_d;
  end

  assign valid_o = valid_q;
  assign data_o  = s2_q;

endmodule

// File: hdl/hsv_level.sv
// ----------------------------------------------------------------------------
// hsv_level
// Stages three and four: scaled q and t numerators, then exact divide by 255.
// ----------------------------------------------------------------------------
module hsv_level import hsv_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [1:0] en_i,
  input  logic       valid_i,
  input  st2_t       data_i,
  output logic [1:0] valid_o,
  output st4_t       data_o
);

  logic [1:0]      valid_q;
  st3_t            s3_d, s3_q;
  st4_t            s4_d, s4_q;
  logic [NumW-1:0] nq, nt;
  logic [31:0]     mq, mt;

  always_comb begin
    // den - s*f and den - s*(1-f) == (255-s)*65536 + s*f
    nq = Den - data_i.sf;
    nt = {Full - data_i.sat, 16'h0000} + data_i.sf;
    mq = 32'(data_i.val) * 32'(nq);
    mt = 32'(data_i.val) * 32'(nt);
    s3_d.sector = data_i.sector;
    s3_d.yq     = mq[31:16];
    s3_d.yt     = mt[31:16];
    s3_d.pv     = data_i.pv;
    s3_d.val    = data_i.val;
  end

  always_comb begin
    s4_d.sector = s3_q.sector;
    s4_d.val    = s3_q.val;
    s4_d.lp     = div255(s3_q.pv);
    s4_d.lq     = div255(s3_q.yq);
    s4_d.lt     = div255(s3_q.yt);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en_i[0]) valid_q[0] <= valid_i;
      if (en_i[1]) valid_q[1] <= valid_q[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) s3_q <= s3_d;
    if (en_i[1]) s4_q <= s4_d;
  end

  assign valid_o = valid_q;
  assign data_o  = s4_q;

endmodule

// File: hdl/hsv_route.sv
// ----------------------------------------------------------------------------
// hsv_route
// Stage five: steer v, p, q and t onto the rgb channels by sector.
// ----------------------------------------------------------------------------
module hsv_route import hsv_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  logic     valid_i,
  input  st4_t     data_i,
  output logic     valid_o,
  output rgb_out_t data_o
);

  logic     valid_q;
  rgb_out_t rgb_d, rgb_q;

  always_comb begin
    case (data_i.sector)
      SEC_RED:     rgb_d = '{red: data_i.val, green: data_i.lt,  blue: data_i.lp};
      SEC_YELLOW:  rgb_d = '{red: data_i.lq,  green: data_i.val, blue: data_i.lp};
      SEC_GREEN:   rgb_d = '{red: data_i.lp,  green: data_i.val, blue: data_i.lt};
      SEC_CYAN:    rgb_d = '{red: data_i.lp,  green: data_i.lq,  blue: data_i.val};
      SEC_BLUE:    rgb_d = '{red: data_i.lt,  green: data_i.lp,  blue: data_i.val};
      SEC_MAGENTA: rgb_d = '{red: data_i.val, green: data_i.lp,  blue: data_i.lq};
      default:     rgb_d = '{red: data_i.val, green: data_i.lp,  blue: data_i.lq};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) rgb_q <= rgb_d;
  end

  assign valid_o = valid_q;
  assign data_o  = rgb_q;

endmodule

// File: hdl/hsv_to_rgb_converter.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// an accepted input beat reaches its output beat through the front, level and route stage registers
// throughput: one beat per cycle while the output is not stalled, set by the five-stage pipeline
// an idle stage soaks up a beat while the output is stalled
// reset: rst_ni low clears all valid bits at once, payload is not reset
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter import hsv_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  hsv_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output rgb_out_t out_data_o
);

  // stage valid bits, stage 1 first
  logic [1:0] front_valid;
  logic [1:0] level_valid;
  logic       route_valid;
  st2_t       front_data;
  st4_t       level_data;

  // per-stage load enables: a stage loads when empty or when the next one
  // moves, so bubbles collapse and nothing is dropped or duplicated
  logic [4:0] en;

  always_comb begin
    en[4] = !route_valid    || !out_stall_i;
    en[3] = !level_valid[1] || en[4];
    en[2] = !level_valid[0] || en[3];
    en[1] = !front_valid[1] || en[2];
    en[0] = !front_valid[0] || en[1];
  end

  assign in_stall_o = !en[0];

  // sector and fraction, s*f and p numerator
  hsv_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en[1:0]),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .valid_o (front_valid),
    .data_o  (front_data)
  );

  // q and t numerators times v, then truncating divide by 255
  hsv_level u_level (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en[3:2]),
    .valid_i (front_valid[1]),
    .data_i  (front_data),
    .valid_o (level_valid),
    .data_o  (level_data)
  );

  // sector routing into the output register
  hsv_route u_route (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en[4]),
    .valid_i (level_valid[1]),
    .data_i  (level_data),
    .valid_o (route_valid),
    .data_o  (out_data_o)
  );

  assign out_valid_o = route_valid;

endmodule
